>>> src/cpp_pkg.sv
// shared constants and types for the configuration packet parser
package cpp_pkg;

	localparam int WORD_BITS     = 16;
	localparam int OUT_CNT_BITS  = 28;
	localparam int CNT_EXT_BITS  = 32;
	localparam int COUNT_BITS_DEF = 28;

	localparam int KIND_BITS = 3;
	localparam int OP_BITS   = 2;
	localparam int REG_BITS  = 6;
	localparam int ROLE_BITS = 3;

	// header type codes
	localparam logic [KIND_BITS-1:0] KIND_T1 = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_T2 = 3'd2;

	typedef enum logic [ROLE_BITS-1:0] {
		ROLE_T1      = 3'd0,
		ROLE_T2      = 3'd1,
		ROLE_OTHER   = 3'd2,
		ROLE_CNT_HI  = 3'd3,
		ROLE_CNT_LO  = 3'd4,
		ROLE_PAYLOAD = 3'd5,
		ROLE_CRC_HI  = 3'd6,
		ROLE_CRC_LO  = 3'd7
	} role_t;

	// item held in the input register
	typedef struct packed {
		logic                 valid;
		logic [WORD_BITS-1:0] word;
	} in_item_t;

endpackage

>>> src/cpp_in_stage.sv
// input register stage with stall back-pressure
module cpp_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          word_valid,
	output logic                          word_stall,
	input  logic [cpp_pkg::WORD_BITS-1:0] stream_word,
	input  logic                          next_ready,
	output cpp_pkg::in_item_t             item_s1
);

	logic                          valid_s1;
	logic [cpp_pkg::WORD_BITS-1:0] word_s1;

	assign word_stall = valid_s1 && !next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!word_stall && word_valid) begin
			word_s1 <= stream_word;
		end
	end

	assign item_s1.valid = valid_s1;
	assign item_s1.word  = word_s1;

endmodule

>>> src/cpp_parser.sv
// packet phase tracking and result register
module cpp_parser #(
	parameter int COUNT_BITS = cpp_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cpp_pkg::in_item_t                 item_s1,
	output logic                              next_ready,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [cpp_pkg::ROLE_BITS-1:0]     word_role,
	output logic [cpp_pkg::KIND_BITS-1:0]     packet_kind,
	output logic [cpp_pkg::OP_BITS-1:0]       packet_opcode,
	output logic [cpp_pkg::REG_BITS-1:0]      target_register,
	output logic [cpp_pkg::OUT_CNT_BITS-1:0]  payload_count,
	output logic [cpp_pkg::OUT_CNT_BITS-1:0]  payload_index,
	output logic [cpp_pkg::WORD_BITS-1:0]     word_out,
	output logic                              packet_end
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CNT_HI  = 3'd1,
		PH_CNT_LO  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC_HI  = 3'd4,
		PH_CRC_LO  = 3'd5
	} phase_t;

	phase_t                            phase_q, phase_d;
	logic [cpp_pkg::KIND_BITS-1:0]     kind_q, kind_d;
	logic [cpp_pkg::OP_BITS-1:0]       op_q, op_d;
	logic [cpp_pkg::REG_BITS-1:0]      reg_q, reg_d;
	logic [COUNT_BITS-1:0]             total_q, total_d;
	logic [COUNT_BITS-1:0]             seen_q, seen_d;
	logic [cpp_pkg::WORD_BITS-1:0]     cnt_hi_q, cnt_hi_d;

	cpp_pkg::role_t                    role;
	logic [COUNT_BITS-1:0]             cnt_out;
	logic [COUNT_BITS-1:0]             idx_out;
	logic                              end_mark;
	logic [cpp_pkg::CNT_EXT_BITS-1:0]  cnt_full;
	logic [cpp_pkg::CNT_EXT_BITS-1:0]  cnt_ext;
	logic [cpp_pkg::CNT_EXT_BITS-1:0]  idx_ext;
	logic [cpp_pkg::WORD_BITS-1:0]     w;
	logic                              advance;

	assign w          = item_s1.word;
	assign next_ready = !result_valid || !result_stall;
	assign advance    = item_s1.valid && next_ready;
	assign cnt_full   = {cnt_hi_q, w};
	assign cnt_ext    = cpp_pkg::CNT_EXT_BITS'(cnt_out);
	assign idx_ext    = cpp_pkg::CNT_EXT_BITS'(idx_out);

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		op_d     = op_q;
		reg_d    = reg_q;
		total_d  = total_q;
		seen_d   = seen_q;
		cnt_hi_d = cnt_hi_q;
		role     = cpp_pkg::ROLE_OTHER;
		cnt_out  = '0;
		idx_out  = '0;
		end_mark = 1'b0;
		unique case (phase_q)
			PH_CNT_HI: begin
				role     = cpp_pkg::ROLE_CNT_HI;
				cnt_hi_d = w;
				phase_d  = PH_CNT_LO;
			end
			PH_CNT_LO: begin
				role    = cpp_pkg::ROLE_CNT_LO;
				total_d = cnt_full[COUNT_BITS-1:0];
				cnt_out = total_d;
				phase_d = (total_d == '0) ? PH_CRC_HI : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				role    = cpp_pkg::ROLE_PAYLOAD;
				cnt_out = total_q;
				idx_out = seen_q;
				seen_d  = seen_q + COUNT_BITS'(1);
				if (seen_d == total_q) begin
					if (kind_q == cpp_pkg::KIND_T2) begin
						phase_d = PH_CRC_HI;
					end else begin
						end_mark = 1'b1;
						phase_d  = PH_HEADER;
					end
				end
			end
			PH_CRC_HI: begin
				role    = cpp_pkg::ROLE_CRC_HI;
				cnt_out = total_q;
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				role     = cpp_pkg::ROLE_CRC_LO;
				cnt_out  = total_q;
				end_mark = 1'b1;
				phase_d  = PH_HEADER;
			end
			default: begin
				// header word: latch the packet fields
				kind_d = w[15:13];
				op_d   = w[12:11];
				reg_d  = w[10:5];
				seen_d = '0;
				if (w[15:13] == cpp_pkg::KIND_T1) begin
					role    = cpp_pkg::ROLE_T1;
					total_d = COUNT_BITS'(w[4:0]);
					cnt_out = total_d;
					if (w[4:0] == 5'd0) begin
						end_mark = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else if (w[15:13] == cpp_pkg::KIND_T2) begin
					role    = cpp_pkg::ROLE_T2;
					total_d = '0;
					phase_d = PH_CNT_HI;
				end else begin
					role     = cpp_pkg::ROLE_OTHER;
					total_d  = '0;
					end_mark = 1'b1;
				end
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			kind_q       <= '0;
			op_q         <= '0;
			reg_q        <= '0;
			total_q      <= '0;
			seen_q       <= '0;
			cnt_hi_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			if (next_ready) begin
				result_valid <= item_s1.valid;
			end
			if (advance) begin
				phase_q  <= phase_d;
				kind_q   <= kind_d;
				op_q     <= op_d;
				reg_q    <= reg_d;
				total_q  <= total_d;
				seen_q   <= seen_d;
				cnt_hi_q <= cnt_hi_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			word_role       <= role;
			packet_kind     <= kind_d;
			packet_opcode   <= op_d;
			target_register <= reg_d;
			payload_count   <= cnt_ext[cpp_pkg::OUT_CNT_BITS-1:0];
			payload_index   <= idx_ext[cpp_pkg::OUT_CNT_BITS-1:0];
			word_out        <= w;
			packet_end      <= end_mark;
		end
	end

endmodule

>>> src/config_packet_parser_16bit_core.sv
// top level of the configuration packet parser
//
// channel | valid        | stall        | payload
// --------+--------------+--------------+--------------------------------------------
// word    | word_valid   | word_stall   | stream_word
// result  | result_valid | result_stall | word_role, packet_kind, packet_opcode,
//         |              |              | target_register, payload_count,
//         |              |              | payload_index, word_out, packet_end
//
// one item per clock sustained while the result is not stalled; each item passes
// through the input register, then the parse logic and the result register
// the phase update is a single step: the parser takes a word every unstalled cycle
// arst_n clears the valid flags and the phase state: the parser expects a header
// a stalled result holds the result register; the input register fills behind it
// and word_stall rises only when both stages are occupied
module config_packet_parser_16bit_core #(
	parameter int COUNT_BITS = cpp_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              word_valid,
	output logic                              word_stall,
	input  logic [cpp_pkg::WORD_BITS-1:0]     stream_word,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [cpp_pkg::ROLE_BITS-1:0]     word_role,
	output logic [cpp_pkg::KIND_BITS-1:0]     packet_kind,
	output logic [cpp_pkg::OP_BITS-1:0]       packet_opcode,
	output logic [cpp_pkg::REG_BITS-1:0]      target_register,
	output logic [cpp_pkg::OUT_CNT_BITS-1:0]  payload_count,
	output logic [cpp_pkg::OUT_CNT_BITS-1:0]  payload_index,
	output logic [cpp_pkg::WORD_BITS-1:0]     word_out,
	output logic                              packet_end
);

	// item in the input register, and whether the parse stage can take it
	cpp_pkg::in_item_t item_s1;
	logic              next_ready;

	// input register: parts the upstream handshake from the parse logic
	cpp_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.stream_word (stream_word),
		.next_ready  (next_ready),
		.item_s1     (item_s1)
	);

	// phase tracking, field decode and the result register
	cpp_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_s1         (item_s1),
		.next_ready      (next_ready),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.word_role       (word_role),
		.packet_kind     (packet_kind),
		.packet_opcode   (packet_opcode),
		.target_register (target_register),
		.payload_count   (payload_count),
		.payload_index   (payload_index),
		.word_out        (word_out),
		.packet_end      (packet_end)
	);

endmodule
